// File: design/rmv_pkg.sv
// shared widths and defaults for the per-station running mean and variance block
package rmv_pkg;
   localparam int STATION_BITS         = 3;
   localparam int SAMPLE_BITS          = 24;
   localparam int VAR_BITS             = 48;
   localparam int COUNT_OUT_BITS       = 16;
   localparam int NUM_CHANNELS_DEFAULT = 8;
   localparam int COUNT_BITS_DEFAULT   = 16;
endpackage

// File: design/running_mean_variance_per_channel_top.sv
// per-station running mean and unbiased variance, shared multiplier and serial divider
//
//   channel   ports                         handshake
//   --------  ----------------------------  --------------------------------------
//   request   req_station_index, req_*_sample  accepted when start && !busy
//   response  rsp_* fields                  valid for one cycle while rsp_strobe
//
// an in-range transaction keeps busy high while six quotients share one restoring
// divider that retires one quotient bit per cycle; each quotient has DIV_BITS =
// 26 + max(COUNT_BITS + 1, 25) bits. a non-positive variance product skips its
// divide, and the first sample of a station skips both variance updates.
// the response strobe rises in the same cycle that busy falls; an out-of-range
// station answers in the cycle after acceptance and busy never rises.
// reset clears the per-station valid bits, so every store reads as zero afterwards.
// busy stays high until the response is registered; the receiver cannot stall.
module running_mean_variance_per_channel_top #(
   parameter int NUM_CHANNELS = rmv_pkg::NUM_CHANNELS_DEFAULT,
   parameter int COUNT_BITS   = rmv_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [rmv_pkg::STATION_BITS-1:0]      req_station_index,
   input  logic signed [rmv_pkg::SAMPLE_BITS-1:0] req_temperature_sample,
   input  logic signed [rmv_pkg::SAMPLE_BITS-1:0] req_humidity_sample,
   output logic                                  rsp_strobe,
   output logic [rmv_pkg::STATION_BITS-1:0]      rsp_station_out,
   output logic [rmv_pkg::COUNT_OUT_BITS-1:0]    rsp_count_out,
   output logic signed [rmv_pkg::SAMPLE_BITS-1:0] rsp_temperature_mean,
   output logic [rmv_pkg::VAR_BITS-1:0]          rsp_temperature_variance,
   output logic signed [rmv_pkg::SAMPLE_BITS-1:0] rsp_humidity_mean,
   output logic [rmv_pkg::VAR_BITS-1:0]          rsp_humidity_variance
);
   import rmv_pkg::*;

   // address width of the per-station stores
   localparam int ADDR_BITS = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   // multiplier operand b covers the count and a sample difference
   localparam int MB        = (COUNT_BITS + 1 > 25) ? COUNT_BITS + 1 : 25;
   localparam int PW        = 25 + MB;
   localparam int DIV_BITS  = PW + 1;
   localparam int CNT_BITS  = $clog2(DIV_BITS);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_READ  = 4'd1;
   localparam logic [3:0] S_LOAD  = 4'd2;
   localparam logic [3:0] S_MMUL  = 4'd3;
   localparam logic [3:0] S_MACC  = 4'd4;
   localparam logic [3:0] S_MDIV  = 4'd5;
   localparam logic [3:0] S_VDIV  = 4'd6;
   localparam logic [3:0] S_PMUL  = 4'd7;
   localparam logic [3:0] S_PCHK  = 4'd8;
   localparam logic [3:0] S_PDIV  = 4'd9;
   localparam logic [3:0] S_SUM   = 4'd10;
   localparam logic [3:0] S_WRITE = 4'd11;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // per-station stores, valid bits stand in for the reset clear
   logic [COUNT_BITS-1:0]         count_mem [NUM_CHANNELS];
   logic [SAMPLE_BITS-1:0]        tmean_mem [NUM_CHANNELS];
   logic [VAR_BITS-1:0]           tvar_mem  [NUM_CHANNELS];
   logic [SAMPLE_BITS-1:0]        hmean_mem [NUM_CHANNELS];
   logic [VAR_BITS-1:0]           hvar_mem  [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0]       valid_ff;

   logic [3:0]                    state_ff, state_in;
   logic [ADDR_BITS-1:0]          addr_ff;
   logic [STATION_BITS-1:0]       station_ff;
   logic signed [SAMPLE_BITS-1:0] xt_ff, xh_ff;
   logic [COUNT_BITS-1:0]         rd_count_ff;
   logic [SAMPLE_BITS-1:0]        rd_tmean_ff, rd_hmean_ff;
   logic [VAR_BITS-1:0]           rd_tvar_ff, rd_hvar_ff;

   logic [COUNT_BITS-1:0]         n_ff, d_ff;
   logic signed [SAMPLE_BITS-1:0] tmean_ff, hmean_ff, old_ff;
   logic [VAR_BITS-1:0]           tvar_ff, hvar_ff, first_ff;
   logic [VAR_BITS:0]             second_ff;
   logic                          q_ff;
   logic                          neg_ff;

   logic signed [PW-1:0]          mul_ff;
   logic [DIV_BITS-1:0]           div_quo_ff;
   logic [COUNT_BITS-1:0]         div_rem_ff, div_den_ff;
   logic [CNT_BITS-1:0]           div_cnt_ff;

   logic                          rsp_strobe_ff;
   logic [STATION_BITS-1:0]       rsp_station_ff;
   logic [COUNT_OUT_BITS-1:0]     rsp_count_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_tmean_ff, rsp_hmean_ff;
   logic [VAR_BITS-1:0]           rsp_tvar_ff, rsp_hvar_ff;

   // station range check on a widened index
   logic [8:0]                    station_wide;
   logic                          in_range;
   assign station_wide = 9'(req_station_index);
   assign in_range     = station_wide < 9'(NUM_CHANNELS);

   // working operands of the quantity in flight
   logic signed [SAMPLE_BITS-1:0] cur_x, cur_mean;
   logic [VAR_BITS-1:0]           cur_var;
   assign cur_x    = q_ff ? xh_ff : xt_ff;
   assign cur_mean = q_ff ? hmean_ff : tmean_ff;
   assign cur_var  = q_ff ? hvar_ff : tvar_ff;

   // shared signed multiplier
   logic signed [24:0]            mul_a;
   logic signed [MB-1:0]          mul_b;
   logic signed [24:0]            diff_new, diff_old;
   logic [MB-1:0]                 d_wide;
   assign diff_new = 25'(cur_x) - 25'(cur_mean);
   assign diff_old = 25'(cur_x) - 25'(old_ff);
   assign d_wide   = MB'(d_ff);
   always_comb begin
      if (state_ff == S_PMUL) begin
         mul_a = diff_new;
         mul_b = MB'(diff_old);
      end else begin
         mul_a = 25'(cur_mean);
         mul_b = $signed(d_wide);
      end
   end

   // mean numerator and its magnitude
   logic signed [DIV_BITS-1:0]    acc;
   logic [DIV_BITS-1:0]           acc_mag;
   assign acc     = DIV_BITS'(mul_ff) + DIV_BITS'(cur_x);
   assign acc_mag = acc[DIV_BITS-1] ? DIV_BITS'(-acc) : DIV_BITS'(acc);

   // one restoring divider step
   logic [COUNT_BITS:0]           div_trial;
   logic                          div_ge;
   logic [COUNT_BITS:0]           div_diff;
   logic [COUNT_BITS-1:0]         rem_nx;
   logic [DIV_BITS-1:0]           quo_nx;
   logic                          div_last;
   assign div_trial = {div_rem_ff, div_quo_ff[DIV_BITS-1]};
   assign div_ge    = div_trial >= {1'b0, div_den_ff};
   assign div_diff  = div_trial - {1'b0, div_den_ff};
   assign rem_nx    = div_ge ? div_diff[COUNT_BITS-1:0] : div_trial[COUNT_BITS-1:0];
   assign quo_nx    = {div_quo_ff[DIV_BITS-2:0], div_ge};
   assign div_last  = div_cnt_ff == CNT_BITS'(DIV_BITS - 1);

   // quotient to signed mean
   logic [24:0]                   mean_mag, mean_sgn;
   assign mean_mag = quo_nx[24:0];
   assign mean_sgn = neg_ff ? 25'(-mean_mag) : mean_mag;

   // first variance term, floor((n-2)*var/(n-1)) as var - ceil(var/(n-1))
   logic [VAR_BITS-1:0]           first_val;
   assign first_val = cur_var - quo_nx[VAR_BITS-1:0]
                      - VAR_BITS'(rem_nx != '0);

   logic [VAR_BITS+1:0]           var_sum;
   logic [VAR_BITS-1:0]           var_sat;
   assign var_sum = VAR_BITS'(first_ff) + (VAR_BITS + 2)'(second_ff);
   assign var_sat = (var_sum[VAR_BITS+1:VAR_BITS] != 2'b00) ? {VAR_BITS{1'b1}}
                                                             : var_sum[VAR_BITS-1:0];

   logic                          prod_pos;
   assign prod_pos = !mul_ff[PW-1] && (mul_ff != '0);

   // loaded count and its saturating increment
   logic [COUNT_BITS-1:0]         cnt_cur, n_new;
   logic                          rd_valid;
   assign rd_valid = valid_ff[addr_ff];
   assign cnt_cur  = rd_valid ? rd_count_ff : '0;
   assign n_new    = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + 1'b1;

   logic [31:0]                   n_wide;
   assign n_wide = 32'(n_ff);

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (start && in_range) state_in = S_READ;
         S_READ:  state_in = S_LOAD;
         S_LOAD:  state_in = S_MMUL;
         S_MMUL:  state_in = S_MACC;
         S_MACC:  state_in = S_MDIV;
         S_MDIV: begin
            if (div_last) begin
               if (d_ff != '0) state_in = S_VDIV;
               else if (!q_ff) state_in = S_MMUL;
               else            state_in = S_WRITE;
            end
         end
         S_VDIV:  if (div_last) state_in = S_PMUL;
         S_PMUL:  state_in = S_PCHK;
         S_PCHK:  state_in = prod_pos ? S_PDIV : S_SUM;
         S_PDIV:  if (div_last) state_in = S_SUM;
         S_SUM:   state_in = q_ff ? S_WRITE : S_MMUL;
         S_WRITE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= (state_ff == S_IDLE && start && !in_range)
                          || (state_ff == S_WRITE);
         if (state_ff == S_WRITE) valid_ff[addr_ff] <= 1'b1;
      end
   end

   // store reads and writes
   always_ff @(posedge clock) begin
      rd_count_ff <= count_mem[addr_ff];
      rd_tmean_ff <= tmean_mem[addr_ff];
      rd_tvar_ff  <= tvar_mem[addr_ff];
      rd_hmean_ff <= hmean_mem[addr_ff];
      rd_hvar_ff  <= hvar_mem[addr_ff];
      if (state_ff == S_WRITE) begin
         count_mem[addr_ff] <= n_ff;
         tmean_mem[addr_ff] <= tmean_ff;
         tvar_mem[addr_ff]  <= tvar_ff;
         hmean_mem[addr_ff] <= hmean_ff;
         hvar_mem[addr_ff]  <= hvar_ff;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               addr_ff        <= station_wide[ADDR_BITS-1:0];
               station_ff     <= req_station_index;
               xt_ff          <= req_temperature_sample;
               xh_ff          <= req_humidity_sample;
               rsp_station_ff <= req_station_index;
               rsp_count_ff   <= '0;
               rsp_tmean_ff   <= '0;
               rsp_tvar_ff    <= '0;
               rsp_hmean_ff   <= '0;
               rsp_hvar_ff    <= '0;
            end
         end
         S_LOAD: begin
            n_ff     <= n_new;
            d_ff     <= n_new - 1'b1;
            tmean_ff <= rd_valid ? rd_tmean_ff : '0;
            hmean_ff <= rd_valid ? rd_hmean_ff : '0;
            tvar_ff  <= rd_valid ? rd_tvar_ff : '0;
            hvar_ff  <= rd_valid ? rd_hvar_ff : '0;
            q_ff     <= 1'b0;
         end
         S_MMUL, S_PMUL: mul_ff <= mul_a * mul_b;
         S_MACC: begin
            neg_ff     <= acc[DIV_BITS-1];
            div_quo_ff <= acc_mag;
            div_rem_ff <= '0;
            div_den_ff <= n_ff;
            div_cnt_ff <= '0;
         end
         S_MDIV: begin
            if (div_last) begin
               old_ff <= cur_mean;
               if (q_ff) hmean_ff <= mean_sgn[23:0];
               else      tmean_ff <= mean_sgn[23:0];
               // variance load, or move on to the next quantity
               div_quo_ff <= DIV_BITS'(cur_var);
               div_rem_ff <= '0;
               div_den_ff <= d_ff;
               div_cnt_ff <= '0;
               if (d_ff == '0) q_ff <= 1'b1;
            end else begin
               div_quo_ff <= quo_nx;
               div_rem_ff <= rem_nx;
               div_cnt_ff <= div_cnt_ff + 1'b1;
            end
         end
         S_VDIV: begin
            div_quo_ff <= quo_nx;
            div_rem_ff <= rem_nx;
            div_cnt_ff <= div_cnt_ff + 1'b1;
            if (div_last) first_ff <= first_val;
         end
         S_PCHK: begin
            div_quo_ff <= DIV_BITS'(unsigned'(mul_ff));
            div_rem_ff <= '0;
            div_den_ff <= d_ff;
            div_cnt_ff <= '0;
            if (!prod_pos) second_ff <= '0;
         end
         S_PDIV: begin
            div_quo_ff <= quo_nx;
            div_rem_ff <= rem_nx;
            div_cnt_ff <= div_cnt_ff + 1'b1;
            if (div_last) second_ff <= quo_nx[VAR_BITS:0];
         end
         S_SUM: begin
            if (q_ff) hvar_ff <= var_sat;
            else      tvar_ff <= var_sat;
            q_ff <= 1'b1;
         end
         S_WRITE: begin
            rsp_station_ff <= station_ff;
            rsp_count_ff   <= n_wide[COUNT_OUT_BITS-1:0];
            rsp_tmean_ff   <= tmean_ff;
            rsp_tvar_ff    <= tvar_ff;
            rsp_hmean_ff   <= hmean_ff;
            rsp_hvar_ff    <= hvar_ff;
         end
         default: ;
      endcase
   end

   assign busy                     = state_ff != S_IDLE;
   assign rsp_strobe               = rsp_strobe_ff;
   assign rsp_station_out          = rsp_station_ff;
   assign rsp_count_out            = rsp_count_ff;
   assign rsp_temperature_mean     = rsp_tmean_ff;
   assign rsp_temperature_variance = rsp_tvar_ff;
   assign rsp_humidity_mean        = rsp_hmean_ff;
   assign rsp_humidity_variance    = rsp_hvar_ff;
endmodule

// File: tb/running_mean_variance_per_channel_top_tb.sv
// self-checking testbench for the per-station running mean and variance block
module running_mean_variance_per_channel_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rmv_pkg::*;

   localparam int NCH       = NUM_CHANNELS_DEFAULT;
   localparam int CNT_BITS  = COUNT_BITS_DEFAULT;
   localparam longint VAR_SAT   = (64'd1 << VAR_BITS) - 1;
   localparam longint COUNT_SAT = (64'd1 << CNT_BITS) - 1;
   // limit covers the slowest transactions plus the idle bursts between them
   localparam int CYCLE_LIMIT = 1400 * 400 * 3;

   typedef struct packed {
      logic [STATION_BITS-1:0]       station;
      logic signed [SAMPLE_BITS-1:0] temp;
      logic signed [SAMPLE_BITS-1:0] hum;
   } reading_type;

   typedef struct packed {
      logic [STATION_BITS-1:0]       station;
      logic [COUNT_OUT_BITS-1:0]     count;
      logic signed [SAMPLE_BITS-1:0] t_mean;
      logic [VAR_BITS-1:0]           t_var;
      logic signed [SAMPLE_BITS-1:0] h_mean;
      logic [VAR_BITS-1:0]           h_var;
   } stats_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [STATION_BITS-1:0]       req_station_index = '0;
   logic signed [SAMPLE_BITS-1:0] req_temperature_sample = '0;
   logic signed [SAMPLE_BITS-1:0] req_humidity_sample = '0;
   logic                          rsp_strobe;
   logic [STATION_BITS-1:0]       rsp_station_out;
   logic [COUNT_OUT_BITS-1:0]     rsp_count_out;
   logic signed [SAMPLE_BITS-1:0] rsp_temperature_mean;
   logic [VAR_BITS-1:0]           rsp_temperature_variance;
   logic signed [SAMPLE_BITS-1:0] rsp_humidity_mean;
   logic [VAR_BITS-1:0]           rsp_humidity_variance;

   running_mean_variance_per_channel_top dut (
      .clock, .reset, .start, .busy,
      .req_station_index, .req_temperature_sample, .req_humidity_sample,
      .rsp_strobe, .rsp_station_out, .rsp_count_out,
      .rsp_temperature_mean, .rsp_temperature_variance,
      .rsp_humidity_mean, .rsp_humidity_variance
   );

   // predictor state, one entry per station
   longint station_count [NCH];
   longint t_mean_acc [NCH];
   longint t_var_acc [NCH];
   longint h_mean_acc [NCH];
   longint h_var_acc [NCH];

   reading_type pending_readings[$];
   stats_type   expected_stats[$];
   int errors = 0;
   int accepted = 0;
   int checked = 0;
   int saturated_hits = 0;
   longint cycles = 0;
   bit quiet_tail = 1'b0;   // no idling in the last part of the run

   // welford step for one quantity, quotients truncate toward zero
   function automatic void welford_step(input longint x, input longint n,
                                        inout longint mean, inout longint var_acc);
      longint old_mean, nw, d, q, first, prod, second, sum;
      old_mean = mean;
      nw = (old_mean * (n - 1) + x) / n;
      mean = nw;
      if (n > 1) begin
         d = n - 1;
         q = var_acc / d;
         first = var_acc - q - ((var_acc % d) != 0 ? 1 : 0);
         prod = (x - nw) * (x - old_mean);
         second = prod > 0 ? prod / d : 0;
         sum = first + second;
         var_acc = sum > VAR_SAT ? VAR_SAT : sum;
      end
   endfunction

   function automatic stats_type predict_stats(input reading_type r);
      stats_type e;
      int s;
      longint n, tm, tv, hm, hv;
      e = '0;
      e.station = r.station;
      if (r.station >= NCH) return e;
      s = r.station;
      n = station_count[s];
      if (n < COUNT_SAT) n++;
      station_count[s] = n;
      tm = t_mean_acc[s]; tv = t_var_acc[s];
      hm = h_mean_acc[s]; hv = h_var_acc[s];
      welford_step(longint'(r.temp), n, tm, tv);
      welford_step(longint'(r.hum), n, hm, hv);
      t_mean_acc[s] = tm; t_var_acc[s] = tv;
      h_mean_acc[s] = hm; h_var_acc[s] = hv;
      e.count  = n[COUNT_OUT_BITS-1:0];
      e.t_mean = tm[SAMPLE_BITS-1:0];
      e.t_var  = tv[VAR_BITS-1:0];
      e.h_mean = hm[SAMPLE_BITS-1:0];
      e.h_var  = hv[VAR_BITS-1:0];
      return e;
   endfunction

   // clock and cycle limit
   initial begin
      forever begin
         #2 clock = ~clock;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout at %0t with %0d transactions outstanding", $time,
                  expected_stats.size());
         $display("running_mean_variance_per_channel_top: mismatch");
         $finish;
      end
   end

   // busy as seen at the last rising edge
   logic busy_at_edge = 1'b1;

   // driver: presents the next reading at the falling edge, inserts idle bursts
   int idle_left = 0;
   bit handed_over;
   always @(negedge clock) begin
      // a transaction was taken at the last rising edge if start was high and busy low
      handed_over = start && !busy_at_edge;
      if (handed_over) begin
         void'(pending_readings.pop_front());
         if (!quiet_tail && $urandom_range(0, 3) == 0) idle_left = $urandom_range(1, 8);
      end
      if (reset) begin
         start <= 1'b0;
      end else if (idle_left > 0) begin
         idle_left = idle_left - 1;
         start <= 1'b0;
      end else if (pending_readings.size() > 0) begin
         start <= 1'b1;
         req_station_index      <= pending_readings[0].station;
         req_temperature_sample <= pending_readings[0].temp;
         req_humidity_sample    <= pending_readings[0].hum;
      end else begin
         start <= 1'b0;
      end
   end

   // accept point, sampled at the rising edge; prediction is made here in order
   always @(posedge clock) begin
      busy_at_edge <= busy;
      if (!reset && start && !busy) begin
         expected_stats.push_back(predict_stats(pending_readings[0]));
         accepted <= accepted + 1;
      end
   end

   // monitor: compares each response strobe with the oldest expectation
   always @(posedge clock) begin
      stats_type e;
      if (!reset && rsp_strobe) begin
         if (expected_stats.size() == 0) begin
            $display("%0t: response with no transaction outstanding, station %0d",
                     $time, rsp_station_out);
            errors++;
         end else begin
            e = expected_stats.pop_front();
            checked++;
            if (e.count == COUNT_OUT_BITS'(COUNT_SAT)) saturated_hits++;
            if (rsp_station_out !== e.station) begin
               $display("%0t: station expected %0d actual %0d", $time, e.station,
                        rsp_station_out);
               errors++;
            end
            if (rsp_count_out !== e.count) begin
               $display("%0t: count expected %0d actual %0d", $time, e.count,
                        rsp_count_out);
               errors++;
            end
            if (rsp_temperature_mean !== e.t_mean) begin
               $display("%0t: temperature mean expected %0d actual %0d", $time,
                        e.t_mean, rsp_temperature_mean);
               errors++;
            end
            if (rsp_temperature_variance !== e.t_var) begin
               $display("%0t: temperature variance expected %0d actual %0d", $time,
                        e.t_var, rsp_temperature_variance);
               errors++;
            end
            if (rsp_humidity_mean !== e.h_mean) begin
               $display("%0t: humidity mean expected %0d actual %0d", $time,
                        e.h_mean, rsp_humidity_mean);
               errors++;
            end
            if (rsp_humidity_variance !== e.h_var) begin
               $display("%0t: humidity variance expected %0d actual %0d", $time,
                        e.h_var, rsp_humidity_variance);
               errors++;
            end
         end
      end
   end

   function automatic logic signed [SAMPLE_BITS-1:0] random_sample(input int style);
      case (style)
         0: return SAMPLE_BITS'($urandom);                      // full range
         1: return SAMPLE_BITS'($signed($urandom_range(0, 2000)) - 1000);
         2: return $urandom_range(0, 1) ? {1'b0, {(SAMPLE_BITS-1){1'b1}}}
                                        : {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         default: return SAMPLE_BITS'($signed($urandom_range(0, 25600)) + 2560);
      endcase
   endfunction

   task automatic queue_reading(input int st, input logic signed [SAMPLE_BITS-1:0] t,
                                input logic signed [SAMPLE_BITS-1:0] h);
      reading_type r;
      r.station = STATION_BITS'(st);
      r.temp = t;
      r.hum = h;
      pending_readings.push_back(r);
   endtask

   localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   initial begin
      int style;
      for (int i = 0; i < NCH; i++) begin
         station_count[i] = 0;
         t_mean_acc[i] = 0; t_var_acc[i] = 0;
         h_mean_acc[i] = 0; h_var_acc[i] = 0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: first sample keeps zero variance, extremes swing the variance
      queue_reading(0, 24'sd0, 24'sd0);
      queue_reading(0, SMAX, SMIN);
      queue_reading(0, SMIN, SMAX);
      queue_reading(0, SMAX, SMIN);
      queue_reading(1, SMIN, SMIN);
      queue_reading(1, SMIN, SMIN);
      queue_reading(1, -24'sd1, 24'sd1);
      queue_reading(2, 24'sd5, -24'sd5);
      queue_reading(2, 24'sd6, -24'sd6);
      queue_reading(3, SMAX, SMAX);
      queue_reading(3, 24'sd0, 24'sd0);
      queue_reading(7, SMAX, SMIN);
      queue_reading(6, 24'sh555555, 24'shAAAAAA);
      queue_reading(5, 24'shAAAAAA, 24'sh555555);

      // random: mostly realistic readings per station, some extremes and noise
      for (int i = 0; i < 1300; i++) begin
         style = $urandom_range(0, 9);
         queue_reading($urandom_range(0, NCH - 1),
                       random_sample(style < 2 ? 0 : style < 3 ? 2 : style < 5 ? 1 : 3),
                       random_sample(style < 2 ? 0 : style < 3 ? 2 : style < 5 ? 1 : 3));
         if (i == 1100) begin
            wait (pending_readings.size() < 50);
            quiet_tail = 1'b1;
         end
      end

      wait (pending_readings.size() == 0 && expected_stats.size() == 0);
      repeat (400) @(posedge clock);
      $display("ran %0d transactions over %0d stations, %0d responses checked",
               accepted, NCH, checked);
      $display("extreme, random and near-constant readings; saturated count hits %0d",
               saturated_hits);
      if (errors == 0 && expected_stats.size() == 0) begin
         $display("running_mean_variance_per_channel_top: match");
      end else begin
         $display("running_mean_variance_per_channel_top: mismatch");
      end
      $finish;
   end
endmodule
